// ===== sv/rls_pkg.sv =====
// Shared types, constants and helpers of the resizing LIFO stack.
package rls_pkg;

	localparam int RLS_MAX_DEPTH    = 1024;
	localparam int RLS_MIN_CAPACITY = 10;
	localparam int RLS_DATA_WIDTH   = 32;

	localparam int RLS_VAL_W  = 32;
	localparam int RLS_CTR_W  = 32;
	localparam int RLS_FRAC_W = 16;
	localparam int RLS_GF_W   = 12;

	localparam logic [RLS_FRAC_W-1:0] RLS_FULL_THR_RST  = 16'd55706;
	localparam logic [RLS_FRAC_W-1:0] RLS_EMPTY_THR_RST = 16'd9830;
	localparam logic [RLS_GF_W-1:0]   RLS_GROW_RST      = 12'd512;
	localparam logic [RLS_FRAC_W-1:0] RLS_SHRINK_RST    = 16'd32768;
	localparam logic [RLS_GF_W-1:0]   RLS_GROW_ONE      = 12'd256;

	localparam logic signed [RLS_VAL_W-1:0] RLS_EMPTY_MARK = -32'sd99;

	typedef enum logic [1:0] {
		CFG_FULL_THR   = 2'd0,
		CFG_EMPTY_THR  = 2'd1,
		CFG_GROW       = 2'd2,
		CFG_SHRINK     = 2'd3
	} rls_cfg_idx_t;

	typedef enum logic {
		KIND_PUSH = 1'b0,
		KIND_POP  = 1'b1
	} rls_kind_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} rls_state_t;

	typedef struct packed {
		logic grew;
		logic shrank;
		logic truncated;
	} rls_flags_t;

	function automatic logic [RLS_CTR_W-1:0] sat_inc(input logic [RLS_CTR_W-1:0] v);
		return (&v) ? v : v + RLS_CTR_W'(1);
	endfunction

endpackage

// ===== sv/resizing_lifo_stack.sv =====
// Top level of the resizing LIFO stack: control, state registers and result channel.
//
// Input channel (in_valid / in_stall): one transaction is a push (kind 0) or a
// pop (kind 1). Output channel (out_valid / out_stall): one result transaction
// per input transaction, in order. Configuration channel (cfg_valid / cfg_ready)
// writes the full and empty thresholds, grow factor and shrink fraction; ready
// is always high and writes belong in idle periods.
// A transaction runs in the idle and execute states: the accept cycle issues the stack memory
// read and registers the threshold and scale products of the current capacity;
// the execute state decides the resize, writes the memory and loads the result.
// The execute state loads the result register, and waits there while an earlier
// result is stalled; a new transaction is accepted only in the idle state.
// The input stalls while a transaction is in work. A stalled result holds,
// and the block holds its execute state until the result register is free, so
// one further transaction can be accepted behind a waiting result.
// Reset clears the count, statistics and result valid, sets capacity to the
// minimum and loads the default configuration. Memory contents need no reset.
module resizing_lifo_stack #(
	parameter int MAX_DEPTH    = rls_pkg::RLS_MAX_DEPTH,
	parameter int MIN_CAPACITY = rls_pkg::RLS_MIN_CAPACITY,
	parameter int DATA_WIDTH   = rls_pkg::RLS_DATA_WIDTH,
	localparam int CW = $clog2(((MAX_DEPTH > MIN_CAPACITY) ? MAX_DEPTH : MIN_CAPACITY) + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic signed [rls_pkg::RLS_VAL_W-1:0] push_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                ok,
	output logic signed [rls_pkg::RLS_VAL_W-1:0] pop_value,
	output logic [CW-1:0]                       item_count,
	output logic [CW-1:0]                       capacity_now,
	output logic                                grew,
	output logic                                shrank,
	output logic                                truncated,
	output logic [rls_pkg::RLS_CTR_W-1:0]       grow_total,
	output logic [rls_pkg::RLS_CTR_W-1:0]       shrink_total,
	output logic [CW-1:0]                       peak_capacity,
	output logic [rls_pkg::RLS_CTR_W-1:0]       push_total,
	output logic [rls_pkg::RLS_CTR_W-1:0]       pop_total,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [rls_pkg::RLS_FRAC_W-1:0]      cfg_data
);
	import rls_pkg::*;

	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	rls_state_t state_q;
	rls_state_t state_d;

	logic [RLS_FRAC_W-1:0] full_thr_q;
	logic [RLS_FRAC_W-1:0] empty_thr_q;
	logic [RLS_GF_W-1:0]   grow_factor_q;
	logic [RLS_FRAC_W-1:0] shrink_frac_q;

	logic [CW-1:0]        count_q;
	logic [CW-1:0]        cap_q;
	logic [CW-1:0]        peak_q;
	logic [RLS_CTR_W-1:0] grow_ctr_q;
	logic [RLS_CTR_W-1:0] shrink_ctr_q;
	logic [RLS_CTR_W-1:0] push_ctr_q;
	logic [RLS_CTR_W-1:0] pop_ctr_q;

	logic                        kind_q;
	logic signed [RLS_VAL_W-1:0] push_value_q;

	logic                        out_valid_q;
	logic                        ok_q;
	logic signed [RLS_VAL_W-1:0] pop_value_q;
	rls_flags_t                  flags_q;

	logic accept;
	logic load;
	logic ram_re;
	logic ram_we;

	logic [AW-1:0]         ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic [DATA_WIDTH-1:0] ram_rdata;

	logic signed [DATA_WIDTH-1:0] rd_s;
	logic signed [63:0]           rd_x;
	logic signed [63:0]           pv_x;

	logic          is_pop;
	logic          room0;
	logic          room1;
	logic          pop_ok;
	logic          chk_en;
	logic [CW-1:0] chk_cnt;
	logic [CW-1:0] rsz_cap;
	logic [CW-1:0] rsz_cnt;
	rls_flags_t    rsz_flags;
	logic [CW-1:0] final_cnt;
	logic          step_ok;

	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		load     = 1'b0;
		case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_EXEC: load = !out_valid_q || !out_stall;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_thr_q    <= RLS_FULL_THR_RST;
			empty_thr_q   <= RLS_EMPTY_THR_RST;
			grow_factor_q <= RLS_GROW_RST;
			shrink_frac_q <= RLS_SHRINK_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (rls_cfg_idx_t'(cfg_index))
				CFG_FULL_THR:  full_thr_q    <= cfg_data;
				CFG_EMPTY_THR: empty_thr_q   <= cfg_data;
				CFG_GROW:      grow_factor_q <= cfg_data[RLS_GF_W-1:0];
				CFG_SHRINK:    shrink_frac_q <= cfg_data;
				default:       full_thr_q    <= full_thr_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q       <= kind;
			push_value_q <= push_value;
		end
	end

	assign ram_re = accept && (rls_kind_t'(kind) == KIND_POP);

	rls_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (MAX_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (AW'(count_q - CW'(1))),
		.rdata (ram_rdata)
	);

	always_comb begin
		is_pop  = rls_kind_t'(kind_q) == KIND_POP;
		room0   = (count_q < cap_q) && (count_q < CW'(MAX_DEPTH));
		pop_ok  = count_q != '0;
		chk_en  = !is_pop || pop_ok;
		if (is_pop) begin
			chk_cnt = count_q - CW'(1);
		end else if (room0) begin
			chk_cnt = count_q + CW'(1);
		end else begin
			chk_cnt = count_q;
		end
	end

	rls_resize #(
		.MAX_DEPTH    (MAX_DEPTH),
		.MIN_CAPACITY (MIN_CAPACITY),
		.CW           (CW)
	) u_resize (
		.clk         (clk),
		.full_thr    (full_thr_q),
		.empty_thr   (empty_thr_q),
		.grow_factor (grow_factor_q),
		.shrink_frac (shrink_frac_q),
		.cap         (cap_q),
		.en          (chk_en),
		.cnt         (chk_cnt),
		.cap_out     (rsz_cap),
		.cnt_out     (rsz_cnt),
		.flags       (rsz_flags)
	);

	always_comb begin
		rd_s  = ram_rdata;
		rd_x  = 64'(rd_s);
		pv_x  = 64'(push_value_q);
		room1 = (rsz_cnt < rsz_cap) && (rsz_cnt < CW'(MAX_DEPTH));
		if (is_pop) begin
			step_ok   = pop_ok;
			final_cnt = pop_ok ? rsz_cnt : count_q;
			ram_waddr = AW'(count_q);
		end else if (room0) begin
			step_ok   = 1'b1;
			final_cnt = rsz_cnt;
			ram_waddr = AW'(count_q);
		end else begin
			step_ok   = room1;
			final_cnt = room1 ? rsz_cnt + CW'(1) : rsz_cnt;
			ram_waddr = AW'(rsz_cnt);
		end
		ram_wdata = pv_x[DATA_WIDTH-1:0];
		ram_we    = load && !is_pop && step_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			cap_q        <= CW'(MIN_CAPACITY);
			peak_q       <= '0;
			grow_ctr_q   <= '0;
			shrink_ctr_q <= '0;
			push_ctr_q   <= '0;
			pop_ctr_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load) begin
				count_q     <= final_cnt;
				cap_q       <= rsz_cap;
				out_valid_q <= 1'b1;
				if (rsz_flags.grew) begin
					grow_ctr_q <= sat_inc(grow_ctr_q);
					if (rsz_cap > peak_q) begin
						peak_q <= rsz_cap;
					end
				end
				if (rsz_flags.shrank) begin
					shrink_ctr_q <= sat_inc(shrink_ctr_q);
				end
				if (is_pop) begin
					pop_ctr_q <= sat_inc(pop_ctr_q);
				end else begin
					push_ctr_q <= sat_inc(push_ctr_q);
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ok_q        <= step_ok;
			pop_value_q <= (is_pop && pop_ok) ? rd_x[RLS_VAL_W-1:0] : RLS_EMPTY_MARK;
			flags_q     <= rsz_flags;
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = ok_q;
	assign pop_value     = pop_value_q;
	assign item_count    = count_q;
	assign capacity_now  = cap_q;
	assign grew          = flags_q.grew;
	assign shrank        = flags_q.shrank;
	assign truncated     = flags_q.truncated;
	assign grow_total    = grow_ctr_q;
	assign shrink_total  = shrink_ctr_q;
	assign peak_capacity = peak_q;
	assign push_total    = push_ctr_q;
	assign pop_total     = pop_ctr_q;

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("stack memory read and write in the same cycle");

	a_cap_stable_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) && ($past(state_q) == ST_EXEC) |-> $stable(cap_q))
		else $error("capacity changed while a transaction waits");

	a_count_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q)
		else $error("count exceeds capacity");

	a_flags_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(flags_q.grew && flags_q.shrank) &&
			(!flags_q.truncated || flags_q.shrank))
		else $error("inconsistent resize flags");

	a_load_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (state_q == ST_IDLE) && out_valid_q)
		else $error("result load did not complete the transaction");

endmodule

// ===== sv/rls_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/rls_resize.sv =====
// Capacity resize unit: registered threshold and scale products, grow/shrink decision.
module rls_resize #(
	parameter int MAX_DEPTH    = rls_pkg::RLS_MAX_DEPTH,
	parameter int MIN_CAPACITY = rls_pkg::RLS_MIN_CAPACITY,
	parameter int CW           = 11
) (
	input  logic                          clk,
	input  logic [rls_pkg::RLS_FRAC_W-1:0] full_thr,
	input  logic [rls_pkg::RLS_FRAC_W-1:0] empty_thr,
	input  logic [rls_pkg::RLS_GF_W-1:0]   grow_factor,
	input  logic [rls_pkg::RLS_FRAC_W-1:0] shrink_frac,
	input  logic [CW-1:0]                 cap,
	input  logic                          en,
	input  logic [CW-1:0]                 cnt,
	output logic [CW-1:0]                 cap_out,
	output logic [CW-1:0]                 cnt_out,
	output rls_pkg::rls_flags_t           flags
);
	import rls_pkg::*;

	localparam int PW = CW + RLS_FRAC_W;
	localparam int GW = CW + RLS_GF_W;

	logic [PW-1:0]       ft_prod_s1;
	logic [PW-1:0]       et_prod_s1;
	logic [GW-1:0]       gr_prod_s1;
	logic [PW-1:0]       sr_prod_s1;
	logic [RLS_GF_W-1:0] gf_eff;

	logic [CW-1:0]   cnt_m1;
	logic [PW-1:0]   lhs;
	logic            grow_hit;
	logic            low_hit;
	logic            do_grow;
	logic            do_shrink;
	logic [CW+3:0]   grow_q;
	logic [CW-1:0]   grow_n;
	logic [CW-1:0]   shrink_raw;
	logic [CW-1:0]   shrink_n;

	assign gf_eff = (grow_factor < RLS_GROW_ONE) ? RLS_GROW_ONE : grow_factor;

	always_ff @(posedge clk) begin
		ft_prod_s1 <= PW'(full_thr) * PW'(cap);
		et_prod_s1 <= PW'(empty_thr) * PW'(cap);
		gr_prod_s1 <= GW'(gf_eff) * GW'(cap);
		sr_prod_s1 <= PW'(shrink_frac) * PW'(cap);
	end

	always_comb begin
		cnt_m1     = cnt - CW'(1);
		lhs        = {cnt_m1, {RLS_FRAC_W{1'b0}}};
		grow_hit   = (cnt != '0) && (lhs >= ft_prod_s1);
		low_hit    = (cnt == '0) || (lhs <= et_prod_s1);
		do_grow    = en && grow_hit;
		do_shrink  = en && !grow_hit && low_hit && (cap > CW'(MIN_CAPACITY));
		grow_q     = gr_prod_s1[GW-1:8];
		grow_n     = (grow_q > (CW+4)'(MAX_DEPTH)) ? CW'(MAX_DEPTH) : grow_q[CW-1:0];
		shrink_raw = cap - sr_prod_s1[PW-1:RLS_FRAC_W];
		shrink_n   = (shrink_raw < CW'(MIN_CAPACITY)) ? CW'(MIN_CAPACITY) : shrink_raw;

		flags.grew      = do_grow;
		flags.shrank    = do_shrink;
		flags.truncated = do_shrink && (cnt > shrink_n);
		cap_out         = do_grow ? grow_n : (do_shrink ? shrink_n : cap);
		cnt_out         = flags.truncated ? shrink_n : cnt;
	end

endmodule

// ===== bench/tb_resizing_lifo_stack.sv =====
// Self-checking testbench of the resizing LIFO stack, with its own stack predictor.
`timescale 1ns / 1ps

module tb_resizing_lifo_stack;
	import rls_pkg::*;

	localparam int CW = $clog2(RLS_MAX_DEPTH + 1);
	localparam int unsigned LIMIT = 1000000;

	typedef longint unsigned u64_t;

	typedef struct packed {
		rls_kind_t       kind;
		logic [RLS_VAL_W-1:0] value;
	} stack_op_t;

	typedef struct packed {
		logic                        ok;
		logic signed [RLS_VAL_W-1:0] pop_value;
		logic [CW-1:0]               item_count;
		logic [CW-1:0]               capacity_now;
		logic                        grew;
		logic                        shrank;
		logic                        truncated;
		logic [RLS_CTR_W-1:0]        grow_total;
		logic [RLS_CTR_W-1:0]        shrink_total;
		logic [CW-1:0]               peak_capacity;
		logic [RLS_CTR_W-1:0]        push_total;
		logic [RLS_CTR_W-1:0]        pop_total;
	} stack_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	rls_kind_t kind = KIND_PUSH;
	logic signed [RLS_VAL_W-1:0] push_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic ok;
	logic signed [RLS_VAL_W-1:0] pop_value;
	logic [CW-1:0] item_count;
	logic [CW-1:0] capacity_now;
	logic grew;
	logic shrank;
	logic truncated;
	logic [RLS_CTR_W-1:0] grow_total;
	logic [RLS_CTR_W-1:0] shrink_total;
	logic [CW-1:0] peak_capacity;
	logic [RLS_CTR_W-1:0] push_total;
	logic [RLS_CTR_W-1:0] pop_total;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	rls_cfg_idx_t cfg_index = CFG_FULL_THR;
	logic [RLS_FRAC_W-1:0] cfg_data = '0;

	resizing_lifo_stack i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.push_value   (push_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.ok           (ok),
		.pop_value    (pop_value),
		.item_count   (item_count),
		.capacity_now (capacity_now),
		.grew         (grew),
		.shrank       (shrank),
		.truncated    (truncated),
		.grow_total   (grow_total),
		.shrink_total (shrink_total),
		.peak_capacity(peak_capacity),
		.push_total   (push_total),
		.pop_total    (pop_total),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// stack predictor state
	logic [RLS_VAL_W-1:0] stk_mem [RLS_MAX_DEPTH];
	int unsigned stk_count = 0;
	int unsigned stk_cap = RLS_MIN_CAPACITY;
	int unsigned stk_peak = 0;
	logic [RLS_CTR_W-1:0] n_grow = '0;
	logic [RLS_CTR_W-1:0] n_shrink = '0;
	logic [RLS_CTR_W-1:0] n_push = '0;
	logic [RLS_CTR_W-1:0] n_pop = '0;
	logic [RLS_FRAC_W-1:0] thr_full = RLS_FULL_THR_RST;
	logic [RLS_FRAC_W-1:0] thr_empty = RLS_EMPTY_THR_RST;
	logic [RLS_GF_W-1:0] grow_fac = RLS_GROW_RST;
	logic [RLS_FRAC_W-1:0] shrink_frac = RLS_SHRINK_RST;
	bit f_grew, f_shrank, f_trunc;

	stack_op_t pending[$];
	stack_result_t result_q[$];
	stack_op_t cur_op = '0;
	int unsigned send_gap = 0;
	int unsigned hold_left = 0;
	bit sender_calm = 1'b0;
	bit receiver_calm = 1'b0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	function automatic logic [RLS_CTR_W-1:0] bump(input logic [RLS_CTR_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic bit has_room();
		return stk_count < stk_cap && stk_count < RLS_MAX_DEPTH;
	endfunction

	function automatic void grow_cap();
		u64_t f, n;
		f = (grow_fac < RLS_GROW_ONE) ? u64_t'(RLS_GROW_ONE) : u64_t'(grow_fac);
		n = (u64_t'(stk_cap) * f) >> 8;
		if (n > RLS_MAX_DEPTH)
			n = u64_t'(RLS_MAX_DEPTH);
		n_grow = bump(n_grow);
		f_grew = 1'b1;
		if (n > stk_peak)
			stk_peak = 32'(n);
		stk_cap = 32'(n);
	endfunction

	function automatic void shrink_cap();
		u64_t cut, n;
		cut = (u64_t'(stk_cap) * u64_t'(shrink_frac)) >> 16;
		n = u64_t'(stk_cap) - cut;
		if (n < RLS_MIN_CAPACITY)
			n = u64_t'(RLS_MIN_CAPACITY);
		n_shrink = bump(n_shrink);
		f_shrank = 1'b1;
		if (stk_count > n) begin
			stk_count = 32'(n);
			f_trunc = 1'b1;
		end
		stk_cap = 32'(n);
	endfunction

	function automatic void resize_check();
		u64_t fill;
		if (stk_count == 0) begin
			if (stk_cap > RLS_MIN_CAPACITY)
				shrink_cap();
		end else begin
			fill = u64_t'(stk_count - 1) << 16;
			if (fill >= u64_t'(thr_full) * u64_t'(stk_cap))
				grow_cap();
			else if (fill <= u64_t'(thr_empty) * u64_t'(stk_cap) && stk_cap > RLS_MIN_CAPACITY)
				shrink_cap();
		end
	endfunction

	function automatic stack_result_t stack_step(input stack_op_t op);
		stack_result_t r;
		r = '0;
		r.pop_value = RLS_EMPTY_MARK;
		f_grew = 1'b0;
		f_shrank = 1'b0;
		f_trunc = 1'b0;
		if (op.kind == KIND_PUSH) begin
			n_push = bump(n_push);
			if (has_room()) begin
				stk_mem[stk_count] = op.value;
				stk_count++;
				resize_check();
				r.ok = 1'b1;
			end else begin
				resize_check();
				if (has_room()) begin
					stk_mem[stk_count] = op.value;
					stk_count++;
					r.ok = 1'b1;
				end
			end
		end else begin
			n_pop = bump(n_pop);
			if (stk_count > 0) begin
				r.pop_value = stk_mem[stk_count - 1];
				stk_count--;
				resize_check();
				r.ok = 1'b1;
			end
		end
		r.item_count = CW'(stk_count);
		r.capacity_now = CW'(stk_cap);
		r.grew = f_grew;
		r.shrank = f_shrank;
		r.truncated = f_trunc;
		r.grow_total = n_grow;
		r.shrink_total = n_shrink;
		r.peak_capacity = CW'(stk_peak);
		r.push_total = n_push;
		r.pop_total = n_pop;
		return r;
	endfunction

	function automatic string show(input stack_result_t r);
		return $sformatf("ok=%0b pop=%0d cnt=%0d cap=%0d g=%0b s=%0b t=%0b gt=%0d st=%0d pk=%0d pu=%0d po=%0d",
			r.ok, $signed(r.pop_value), r.item_count, r.capacity_now, r.grew, r.shrank,
			r.truncated, r.grow_total, r.shrink_total, r.peak_capacity, r.push_total,
			r.pop_total);
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99, 0);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 4);
	endfunction

	function automatic logic [RLS_VAL_W-1:0] pick_value();
		case ($urandom_range(9, 0))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// input driver
	always @(posedge clk) begin : drive
		bit take;
		if (arst_n) begin
			take = !in_valid;
			if (in_valid && !in_stall) begin
				result_q.push_back(stack_step(cur_op));
				take = 1'b1;
			end
			if (take) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending.size() > 0) begin
					cur_op = pending.pop_front();
					kind <= cur_op.kind;
					push_value <= cur_op.value;
					in_valid <= 1'b1;
					send_gap = sender_calm ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall
	always @(posedge clk) begin : watch
		stack_result_t got, want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {ok, pop_value, item_count, capacity_now, grew, shrank, truncated,
					grow_total, shrink_total, peak_capacity, push_total, pop_total};
				if (result_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transaction: %s", show(got));
				end else begin
					want = result_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch\n  expected %s\n  actual   %s", show(want),
								show(got));
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				hold_left = receiver_calm ? 0 : pick_gap();
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles >= LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic drain();
		while (pending.size() != 0 || in_valid || result_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input rls_cfg_idx_t idx, input logic [RLS_FRAC_W-1:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_FULL_THR:  thr_full = d;
			CFG_EMPTY_THR: thr_empty = d;
			CFG_GROW:      grow_fac = d[RLS_GF_W-1:0];
			CFG_SHRINK:    shrink_frac = d;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_cfg(input logic [15:0] ft, input logic [15:0] et, input logic [15:0] gf,
		input logic [15:0] sf);
		drain();
		cfg_write(CFG_FULL_THR, ft);
		cfg_write(CFG_EMPTY_THR, et);
		cfg_write(CFG_GROW, gf);
		cfg_write(CFG_SHRINK, sf);
	endtask

	task automatic queue_push(input logic [RLS_VAL_W-1:0] v);
		pending.push_back({KIND_PUSH, v});
	endtask

	task automatic queue_pop();
		pending.push_back({KIND_POP, pick_value()});
	endtask

	task automatic random_ops(input int n, input int unsigned push_pct);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99, 0) < push_pct)
				queue_push(pick_value());
			else
				queue_pop();
		end
	endtask

	initial begin : main
		logic [15:0] ft, et, gf, sf;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty pop under the reset configuration
		queue_pop();
		// grow factor below one: the tenth push grows in place, the eleventh meets a full stack
		set_cfg(RLS_FULL_THR_RST, RLS_EMPTY_THR_RST, 16'd0, RLS_SHRINK_RST);
		queue_push(32'h7FFF_FFFF);
		queue_push(32'h8000_0000);
		queue_push(32'h0000_0000);
		queue_push(32'hFFFF_FFFF);
		queue_push(RLS_EMPTY_MARK);
		queue_push(32'h0000_0001);
		for (int i = 0; i < 5; i++)
			queue_push($urandom);
		// full stack rescued by a growth
		set_cfg(RLS_FULL_THR_RST, RLS_EMPTY_THR_RST, 16'd512, RLS_SHRINK_RST);
		queue_push($urandom);
		// shrink below the fill truncates
		set_cfg(16'hFFFF, 16'hFFFF, 16'd512, 16'hFFFF);
		queue_push($urandom);
		set_cfg(16'd0, 16'hFFFF, 16'd512, 16'hFFFF);
		queue_push($urandom);
		// shrink event with zero fraction
		set_cfg(16'hFFFF, 16'hFFFF, 16'd512, 16'd0);
		queue_pop();
		// largest factor, clamped at the memory depth
		set_cfg(16'd0, 16'd0, 16'hFFFF, 16'd32768);
		queue_push($urandom);
		queue_push($urandom);
		set_cfg(RLS_FULL_THR_RST, RLS_EMPTY_THR_RST, 16'(RLS_GROW_RST), RLS_SHRINK_RST);
		repeat (5) queue_pop();

		for (int p = 0; p < 10; p++) begin
			case ($urandom_range(5, 0))
				0: ft = 16'd0;
				1: ft = 16'hFFFF;
				2: ft = RLS_FULL_THR_RST;
				default: ft = 16'($urandom_range(65535, 32768));
			endcase
			case ($urandom_range(5, 0))
				0: et = 16'd0;
				1: et = 16'hFFFF;
				2: et = RLS_EMPTY_THR_RST;
				default: et = 16'($urandom_range(26000, 0));
			endcase
			case ($urandom_range(5, 0))
				0: gf = 16'($urandom_range(255, 0));
				1: gf = 16'd4095;
				2: gf = 16'd256;
				3: gf = 16'($urandom_range(65535, 0));
				default: gf = 16'($urandom_range(1024, 300));
			endcase
			case ($urandom_range(4, 0))
				0: sf = 16'd0;
				1: sf = 16'hFFFF;
				2: sf = 16'($urandom_range(65535, 0));
				default: sf = 16'($urandom_range(40000, 8192));
			endcase
			set_cfg(ft, et, gf, sf);
			sender_calm = ($urandom_range(3, 0) == 0);
			receiver_calm = ($urandom_range(3, 0) == 0);
			for (int s = 0; s < 3; s++) begin
				case ($urandom_range(3, 0))
					0: random_ops(21, 25);
					1: random_ops(21, 50);
					2: random_ops(21, 65);
					default: random_ops(21, 85);
				endcase
			end
		end

		// grow to the memory depth under steady pushing, then unwind
		set_cfg(16'd0, 16'd0, 16'd4095, RLS_SHRINK_RST);
		sender_calm = 1'b0;
		receiver_calm = 1'b0;
		random_ops(140, 100);
		set_cfg(RLS_FULL_THR_RST, RLS_EMPTY_THR_RST, 16'(RLS_GROW_RST), RLS_SHRINK_RST);
		random_ops(60, 30);

		drain();
		repeat (10) @(negedge clk);
		if (mismatches == 0 && result_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== resizing_lifo_stack.f =====
sv/rls_pkg.sv
sv/rls_ram.sv
sv/rls_resize.sv
sv/resizing_lifo_stack.sv
bench/tb_resizing_lifo_stack.sv
